// ===== sv/pwrq_pkg.sv =====
`timescale 1ns / 1ps

package pwrq_pkg;

	// table size and stored coordinate width
	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;

	// fixed widths of the request and result fields
	localparam int FIELD_W   = 16;
	localparam int SIZE_W    = 15;
	localparam int OUT_IDX_W = 6;

	// derived widths
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int BND_W = EXT_W + 2;

	// request commands
	typedef enum logic [1:0] {
		CMD_RESTART = 2'd0,
		CMD_INSERT  = 2'd1,
		CMD_CORNER  = 2'd2,
		CMD_CENTRE  = 2'd3
	} cmd_t;

	// one result handed from the scan sequencer to the output register
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             hit;
		logic             last;
	} push_t;

endpackage

// ===== sv/pwrq_req_if.sv =====
`timescale 1ns / 1ps

interface pwrq_req_if import pwrq_pkg::*; ();

	logic                     valid;
	logic                     ready;
	cmd_t                     cmd;
	logic signed [FIELD_W-1:0] px;
	logic signed [FIELD_W-1:0] py;
	logic [SIZE_W-1:0]        win_width;
	logic [SIZE_W-1:0]        win_height;

	modport source (
		output valid, cmd, px, py, win_width, win_height,
		input  ready
	);

	modport sink (
		input  valid, cmd, px, py, win_width, win_height,
		output ready
	);

endinterface

// ===== sv/pwrq_rsp_if.sv =====
`timescale 1ns / 1ps

interface pwrq_rsp_if import pwrq_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic [OUT_IDX_W-1:0] point_index;
	logic                 hit;
	logic                 last;

	modport source (
		output valid, point_index, hit, last,
		input  ready
	);

	modport sink (
		input  valid, point_index, hit, last,
		output ready
	);

endinterface

// ===== sv/pwrq_ram.sv =====
`timescale 1ns / 1ps

module pwrq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/pwrq_scan.sv =====
`timescale 1ns / 1ps

module pwrq_scan import pwrq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pwrq_req_if.sink   req,
	output push_t      push,
	input  logic       push_ready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} state_t;

	state_t                    state_q;
	logic                      is_query_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          addr_q;
	logic [CNT_W-1:0]          limit_q;
	logic [MAX_POINTS-1:0]     live_q;
	logic signed [BND_W-1:0]   x0_q, x1_q, y0_q, y1_q;
	logic                      vld_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      pend_vld_q;
	logic [IDX_W-1:0]          pend_idx_q;

	logic                      req_fire;
	logic                      full;
	logic                      ins_fire;
	logic signed [COORD_BITS-1:0] px_c, py_c;
	logic signed [BND_W-1:0]   xc, yc, w_ext, h_ext;
	logic signed [BND_W-1:0]   qx0, qy0, qx1, qy1;
	logic                      more;
	logic [2*COORD_BITS-1:0]   rdata;
	logic signed [COORD_BITS-1:0] sx, sy;
	logic signed [BND_W-1:0]   ex, ey;
	logic                      in_win;
	logic                      hit_s1;
	logic                      stall;
	logic                      advance;
	logic                      re;

	// low COORD_BITS of the zero-extended field, read as two's complement
	function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [FIELD_W-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[COORD_BITS-1:0];
	endfunction

	// request side
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(MAX_POINTS));
	assign ins_fire  = req_fire && (req.cmd == CMD_INSERT) && !full;

	// widened window bounds
	always_comb begin
		px_c  = to_coord(req.px);
		py_c  = to_coord(req.py);
		xc    = {{(BND_W-COORD_BITS){px_c[COORD_BITS-1]}}, px_c};
		yc    = {{(BND_W-COORD_BITS){py_c[COORD_BITS-1]}}, py_c};
		w_ext = $signed({{(BND_W-SIZE_W){1'b0}}, req.win_width});
		h_ext = $signed({{(BND_W-SIZE_W){1'b0}}, req.win_height});
		if (req.cmd == CMD_CENTRE) begin
			qx0 = xc - (w_ext >>> 1);
			qy0 = yc - (h_ext >>> 1);
		end else begin
			qx0 = xc;
			qy0 = yc;
		end
		qx1 = qx0 + w_ext;
		qy1 = qy0 + h_ext;
	end

	// point table: x in the low half, y in the high half
	pwrq_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ins_fire),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({py_c, px_c}),
		.re    (re),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// window test on the entry held in the read data register
	always_comb begin
		sx     = rdata[COORD_BITS-1:0];
		sy     = rdata[2*COORD_BITS-1:COORD_BITS];
		ex     = {{(BND_W-COORD_BITS){sx[COORD_BITS-1]}}, sx};
		ey     = {{(BND_W-COORD_BITS){sy[COORD_BITS-1]}}, sy};
		in_win = (ex >= x0_q) && (ex <= x1_q) && (ey >= y0_q) && (ey <= y1_q);
		hit_s1 = vld_s1 && live_q[idx_s1] && in_win;
	end

	// scan flow: hold the read stage while a pending hit cannot be handed on
	assign more    = (addr_q != limit_q);
	assign stall   = is_query_q && hit_s1 && pend_vld_q && !push_ready;
	assign advance = (state_q == ST_SCAN) && !stall;
	assign re      = advance && more;

	// results toward the output register
	always_comb begin
		push = '0;
		unique case (state_q)
			ST_SCAN: begin
				push.valid = is_query_q && hit_s1 && pend_vld_q;
				push.idx   = pend_idx_q;
				push.hit   = 1'b1;
				push.last  = 1'b0;
			end
			ST_FINAL: begin
				push.valid = 1'b1;
				push.idx   = pend_vld_q ? pend_idx_q : '0;
				push.hit   = pend_vld_q;
				push.last  = 1'b1;
			end
			default: begin
				push = '0;
			end
		endcase
	end

	// bounds; an insert uses a one-point window to find an older duplicate
	always_ff @(posedge clk) begin
		if (req_fire) begin
			if (req.cmd == CMD_INSERT) begin
				x0_q <= xc;
				x1_q <= xc;
				y0_q <= yc;
				y1_q <= yc;
			end else begin
				x0_q <= qx0;
				x1_q <= qx1;
				y0_q <= qy0;
				y1_q <= qy1;
			end
		end
	end

	// sequencer, live bits and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			is_query_q <= 1'b0;
			count_q    <= '0;
			addr_q     <= '0;
			limit_q    <= '0;
			live_q     <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			pend_vld_q <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (req.cmd)
							CMD_RESTART: begin
								live_q  <= '0;
								count_q <= '0;
							end
							CMD_INSERT: begin
								if (!full) begin
									live_q[count_q[IDX_W-1:0]] <= 1'b1;
									count_q    <= count_q + CNT_W'(1);
									addr_q     <= '0;
									limit_q    <= count_q;
									is_query_q <= 1'b0;
									vld_s1     <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							CMD_CORNER, CMD_CENTRE: begin
								addr_q     <= '0;
								limit_q    <= count_q;
								is_query_q <= 1'b1;
								pend_vld_q <= 1'b0;
								vld_s1     <= 1'b0;
								state_q    <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (advance) begin
						vld_s1 <= more;
						idx_s1 <= addr_q[IDX_W-1:0];
						if (more) begin
							addr_q <= addr_q + CNT_W'(1);
						end
						if (hit_s1) begin
							if (is_query_q) begin
								pend_vld_q <= 1'b1;
								pend_idx_q <= idx_s1;
							end else begin
								live_q[idx_s1] <= 1'b0;
							end
						end
						if (!more && !vld_s1) begin
							state_q <= is_query_q ? ST_FINAL : ST_IDLE;
						end
					end
				end
				ST_FINAL: begin
					if (push_ready) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/pwrq_out.sv =====
`timescale 1ns / 1ps

module pwrq_out import pwrq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       push_ready,
	pwrq_rsp_if.source rsp
);

	logic             vld_q;
	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic             last_q;

	// register takes a result when empty or being drained this cycle
	assign push_ready = !vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push.valid && push_ready) begin
			vld_q <= 1'b1;
		end else if (rsp.ready) begin
			vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (push.valid && push_ready) begin
			idx_q  <= push.idx;
			hit_q  <= push.hit;
			last_q <= push.last;
		end
	end

	assign rsp.valid       = vld_q;
	assign rsp.point_index = OUT_IDX_W'(idx_q);
	assign rsp.hit         = hit_q;
	assign rsp.last        = last_q;

endmodule

// ===== sv/point_window_range_query.sv =====
`timescale 1ns / 1ps

// Window range query over a table of up to MAX_POINTS integer points.
// req carries one request: cmd 0 restarts loading and clears the table,
// cmd 1 inserts a point (it takes the next arrival index; a live older
// point at the same position stops being live), cmd 2 and 3 query a
// window given by corner or centre plus width and height.
// rsp returns, for a query, the indices of all live points in the window
// in ascending order, the final one with last set; an empty window gives
// one result with hit low. Restarts and inserts give no result.
// An insert or a query scans the n loaded entries through the point memory
// read port, one per cycle while the scan is not stalled; a query then
// hands on its final result, which reaches rsp through the result register.
// One request is worked on at a time; req.ready is high only when idle.
// When rsp stalls, the result register holds and the scan stops at the
// next hit until a slot frees up; no result is dropped.
// Reset clears the fill count, the live bits and all handshake state at
// once; the stored coordinates need no clearing.
module point_window_range_query import pwrq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pwrq_req_if.sink   req,
	pwrq_rsp_if.source rsp
);

	push_t push;
	logic  push_ready;

	// scan sequencer with point memory and live bits
	pwrq_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push       (push),
		.push_ready (push_ready)
	);

	// result register toward rsp
	pwrq_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.rsp        (rsp)
	);

endmodule
